### rtl/gap_buffer_text_store_unit_macros.svh
// ----------------------------------------------------------------------------
// Gap buffer text store: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_TEXT_STORE_UNIT_MACROS_SVH
`define GAP_BUFFER_TEXT_STORE_UNIT_MACROS_SVH

// Same-cycle implication.
`define GBTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gap buffer assertion failed (same cycle)");

// Next-cycle implication.
`define GBTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gap buffer assertion failed (next cycle)");

`endif

### rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// Gap buffer text store package
// Sizes, operation and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gbts_pkg;

	// Number of byte cells in the store.
	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);

	// Field widths fixed by the stream format.
	localparam int FUNC_W   = 2;
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 11;
	localparam int STATUS_W = 2;
	localparam int OUT_W    = STATUS_W + CHAR_W + POS_W + POS_W;
	localparam int IN_W     = ((CHAR_W + POS_W + 7) / 8) * 8;

	// Internal counts hold 0..CAPACITY and any position value.
	localparam int CNT_W = (ADDR_W + 1 > POS_W) ? ADDR_W + 1 : POS_W;

	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] OP_MOVE   = 2'd2;
	localparam logic [FUNC_W-1:0] OP_READ   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	// Commands from the controller.
	typedef struct packed {
		logic load;    // capture an accepted item, start its lookup read
		logic step;    // carry one byte across the gap
		logic finish;  // commit the operation and load the result register
	} cmd_t;

	// Status back to the controller.
	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic              at_target;  // cursor has reached the move target
	} sts_t;

endpackage

### rtl/gbts_datapath.sv
// ----------------------------------------------------------------------------
// Gap buffer datapath
// Byte store, gap pointers, move copy stage and the result register.
// ----------------------------------------------------------------------------
module gbts_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gbts_pkg::cmd_t                     cmd,
	output gbts_pkg::sts_t                     sts,
	input  logic [gbts_pkg::FUNC_W-1:0]        in_func,
	input  logic [gbts_pkg::CHAR_W-1:0]        in_char,
	input  logic [gbts_pkg::POS_W-1:0]         in_pos,
	output logic [gbts_pkg::OUT_W-1:0]         result
);

	localparam int AW = gbts_pkg::ADDR_W;
	localparam int CW = gbts_pkg::CNT_W;

	logic [gbts_pkg::CHAR_W-1:0] mem_q [gbts_pkg::CAPACITY];

	logic [CW-1:0]               gb_q, gf_q;
	logic [gbts_pkg::FUNC_W-1:0] op_q;
	logic [gbts_pkg::CHAR_W-1:0] ch_q;
	logic [CW-1:0]               pos_q, tgt_q;
	logic [gbts_pkg::CHAR_W-1:0] rdata_q;
	logic                        wr_s1;
	logic [AW-1:0]               dst_s1;
	logic [gbts_pkg::OUT_W-1:0]  res_q;

	logic [CW-1:0]                 gap_len, len, pos_ext, idx, tgt_nx;
	logic [CW-1:0]                 gb_nx, len_nx;
	logic                          left, full;
	logic [CW-1:0]                 src, dst;
	logic [gbts_pkg::STATUS_W-1:0] status;
	logic [gbts_pkg::CHAR_W-1:0]   char_nx;
	logic                          we;
	logic [AW-1:0]                 waddr;
	logic [gbts_pkg::CHAR_W-1:0]   wdata;

	always_comb begin
		gap_len = gf_q - gb_q;
		len     = CW'(gbts_pkg::CAPACITY) - gap_len;
		pos_ext = CW'(in_pos);
		tgt_nx  = (pos_ext > len) ? len : pos_ext;
		idx     = (pos_ext < gb_q) ? pos_ext : pos_ext + gap_len;
		full    = (gb_q == gf_q);
		left    = (gb_q > tgt_q);
		src     = left ? gb_q - CW'(1) : gf_q;
		dst     = left ? gf_q - CW'(1) : gb_q;
	end

	// Commit of the current operation.
	always_comb begin
		gb_nx   = gb_q;
		status  = gbts_pkg::ST_OK;
		char_nx = '0;
		case (op_q)
			gbts_pkg::OP_INSERT: begin
				if (full) begin
					status = gbts_pkg::ST_FULL;
				end else begin
					gb_nx = gb_q + CW'(1);
				end
			end
			gbts_pkg::OP_DELETE: begin
				if (gb_q == '0) begin
					status = gbts_pkg::ST_EMPTY;
				end else begin
					gb_nx = gb_q - CW'(1);
				end
			end
			gbts_pkg::OP_MOVE: begin
				status = gbts_pkg::ST_OK;
			end
			default: begin
				if (pos_q >= len) begin
					status = gbts_pkg::ST_RANGE;
				end else begin
					char_nx = rdata_q;
				end
			end
		endcase
		len_nx = CW'(gbts_pkg::CAPACITY) - (gf_q - gb_nx);
	end

	// One write port: the pending move write or an insert.
	always_comb begin
		we    = 1'b0;
		waddr = gb_q[AW-1:0];
		wdata = ch_q;
		if (wr_s1) begin
			we    = 1'b1;
			waddr = dst_s1;
			wdata = rdata_q;
		end else if (cmd.finish && op_q == gbts_pkg::OP_INSERT && !full) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.load) begin
			rdata_q <= mem_q[idx[AW-1:0]];
		end else if (cmd.step) begin
			rdata_q <= mem_q[src[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gb_q  <= '0;
			gf_q  <= CW'(gbts_pkg::CAPACITY);
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= cmd.step;
			if (cmd.step) begin
				if (left) begin
					gb_q <= gb_q - CW'(1);
					gf_q <= gf_q - CW'(1);
				end else begin
					gb_q <= gb_q + CW'(1);
					gf_q <= gf_q + CW'(1);
				end
			end else if (cmd.finish) begin
				gb_q <= gb_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_func;
			ch_q  <= in_char;
			pos_q <= pos_ext;
			tgt_q <= tgt_nx;
		end
		if (cmd.step) begin
			dst_s1 <= dst[AW-1:0];
		end
		if (cmd.finish) begin
			res_q <= {len_nx[gbts_pkg::POS_W-1:0], gb_nx[gbts_pkg::POS_W-1:0],
				char_nx, status};
		end
	end

	assign sts.op        = op_q;
	assign sts.at_target = (gb_q == tgt_q);
	assign result        = res_q;

endmodule

### rtl/gbts_ctrl.sv
// ----------------------------------------------------------------------------
// Gap buffer controller
// Accepts one item at a time, runs move copies and owns the result valid.
// ----------------------------------------------------------------------------
module gbts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  gbts_pkg::sts_t sts,
	output gbts_pkg::cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic valid_q;
	logic out_free, moving;

	always_comb begin
		out_free   = !valid_q || out_ready;
		moving     = (sts.op == gbts_pkg::OP_MOVE) && !sts.at_target;
		in_ready   = (state_q == S_IDLE);
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.step   = (state_q == S_EXEC) && moving;
		cmd.finish = (state_q == S_EXEC) && !moving && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.finish) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;

endmodule

### rtl/gap_buffer_text_store_unit.sv
// Insert, delete and read commit in the execute state, once the result register is free.
// A cursor move first stays in the execute state while it carries its bytes across the gap.
// Items are taken one at a time: the next is accepted only after the last commits;
// a result that is not taken holds the block, and a move holds it during its copy steps.
// Reset: the cursor and the text length go to zero; the byte store is not cleared.
// ----------------------------------------------------------------------------
// Gap buffer text store unit
// Fixed-capacity text buffer with insert, backspace, cursor move and read.
// ----------------------------------------------------------------------------
`include "gap_buffer_text_store_unit_macros.svh"

module gap_buffer_text_store_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input item stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gbts_pkg::IN_W-1:0]     s_tdata,   // char_in[7:0], position[18:8]
	input  logic [gbts_pkg::FUNC_W-1:0]   s_tuser,   // func[1:0]
	// Result item stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gbts_pkg::OUT_W-1:0]    m_tdata    // status[1:0], char_out[9:2],
	                                                 // cursor[20:10], text_length[31:21]
);

	// The controller and datapath talk only through these two groups.
	gbts_pkg::cmd_t cmd;
	gbts_pkg::sts_t sts;

	// Unpack the input item. The operation code rides on tuser.
	logic [gbts_pkg::CHAR_W-1:0] char_in;
	logic [gbts_pkg::POS_W-1:0]  position;

	assign char_in  = s_tdata[gbts_pkg::CHAR_W-1:0];
	assign position = s_tdata[gbts_pkg::CHAR_W +: gbts_pkg::POS_W];

	// The controller admits one item at a time. A move stays in the execute
	// state while it carries bytes across the gap, one per cycle; every other
	// operation commits there once the result register is free. The result
	// register may still hold an untaken item while the next one is accepted.
	gbts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath keeps the store, the gap pointers and the result register.
	// A read looks up its byte during the acceptance cycle so the registered
	// memory data is ready when the item commits.
	gbts_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_func  (s_tuser),
		.in_char  (char_in),
		.in_pos   (position),
		.result   (m_tdata)
	);

	// The cursor reported in a result never lies beyond the text length.
	`GBTS_ASSERT_NOW(a_cursor_in_text, m_tvalid, m_tdata[20:10] <= m_tdata[31:21])
	// Only one item is in flight: right after an acceptance the input is closed.
	`GBTS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	// A copy step never falls in the same cycle as a commit or a load.
	`GBTS_ASSERT_NOW(a_step_or_finish, cmd.step, !cmd.finish && !cmd.load)

endmodule

### test/gap_buffer_text_store_unit_tb.sv
// ----------------------------------------------------------------------------
// Gap buffer text store unit: self-checking testbench
// A directed table and a long random edit session are pushed through the item
// stream. A behavioral copy of the gap buffer predicts the results not typed in
// by hand; each is checked field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_unit_tb;

	// One result item as the block reports it.
	typedef struct packed {
		logic [gbts_pkg::STATUS_W-1:0] status;
		logic [gbts_pkg::CHAR_W-1:0]   char_out;
		logic [gbts_pkg::POS_W-1:0]    cursor;
		logic [gbts_pkg::POS_W-1:0]    text_length;
	} edit_result_t;

	// One row of the directed table. Rows with known_result set carry the
	// result typed in by hand; all others are checked against the predictor.
	typedef struct {
		logic [gbts_pkg::FUNC_W-1:0] func;
		logic [gbts_pkg::CHAR_W-1:0] char_in;
		logic [gbts_pkg::POS_W-1:0]  position;
		bit                          known_result;
		edit_result_t                result;
	} edit_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [gbts_pkg::IN_W-1:0]     s_tdata;
	logic [gbts_pkg::FUNC_W-1:0]   s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [gbts_pkg::OUT_W-1:0]    m_tdata;

	// Shadow copy of the buffer: the byte cells and the two gap edges.
	logic [gbts_pkg::CHAR_W-1:0]   text_mem [gbts_pkg::CAPACITY];
	int                            gap_lo;
	int                            gap_hi;

	edit_result_t                  pending_results [$];
	edit_row_t                     directed_rows [$];
	int                            mismatch_count;
	int                            results_checked;
	int                            op_count [4];
	int                            status_count [4];
	int                            peak_length;
	bit                            no_idle;

	gap_buffer_text_store_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog. A move carries at most the capacity in bytes across the gap,
	// so even a run of nothing but full-length moves under heavy stalls
	// finishes far inside this bound.
	initial begin
		#100_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int shadow_length();
		return gbts_pkg::CAPACITY - (gap_hi - gap_lo);
	endfunction

	// Applies one edit to the shadow buffer and returns the result it gives.
	function automatic edit_result_t apply_edit(logic [gbts_pkg::FUNC_W-1:0] func,
			logic [gbts_pkg::CHAR_W-1:0] char_in, logic [gbts_pkg::POS_W-1:0] position);
		edit_result_t res;
		int target;
		int span;
		res.status   = gbts_pkg::ST_OK;
		res.char_out = '0;
		case (func)
			gbts_pkg::OP_INSERT: begin
				if (gap_lo == gap_hi) begin
					res.status = gbts_pkg::ST_FULL;
				end else begin
					text_mem[gap_lo] = char_in;
					gap_lo++;
				end
			end
			gbts_pkg::OP_DELETE: begin
				// Backspace only pulls the cursor back; the byte stays put.
				if (gap_lo == 0) begin
					res.status = gbts_pkg::ST_EMPTY;
				end else begin
					gap_lo--;
				end
			end
			gbts_pkg::OP_MOVE: begin
				target = (int'(position) > shadow_length()) ? shadow_length()
					: int'(position);
				if (target < gap_lo) begin
					// Bytes before the cursor slide to the far side of the gap.
					// Walk downward so an overlapping copy stays intact.
					span = gap_lo - target;
					gap_lo -= span;
					gap_hi -= span;
					for (int i = span - 1; i >= 0; i--) begin
						text_mem[gap_hi + i] = text_mem[gap_lo + i];
					end
				end else if (target > gap_lo) begin
					span = target - gap_lo;
					for (int i = 0; i < span; i++) begin
						text_mem[gap_lo + i] = text_mem[gap_hi + i];
					end
					gap_lo += span;
					gap_hi += span;
				end
			end
			default: begin
				if (int'(position) >= shadow_length()) begin
					res.status = gbts_pkg::ST_RANGE;
				end else if (int'(position) < gap_lo) begin
					res.char_out = text_mem[position];
				end else begin
					res.char_out = text_mem[int'(position) + gap_hi - gap_lo];
				end
			end
		endcase
		res.cursor      = gbts_pkg::POS_W'(gap_lo);
		res.text_length = gbts_pkg::POS_W'(shadow_length());
		return res;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		$display("mismatch on result %0d: %s expected %0d got %0d",
			results_checked, what, want, got);
		mismatch_count++;
	endtask

	// Source gaps: mostly none or short, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) begin
			return 0;
		end else if (r < 96) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(20, 80);
	endfunction

	// Presents one item after a random gap and holds it until it is taken.
	// On acceptance the predictor runs; a typed result replaces its answer.
	task automatic send_edit(logic [gbts_pkg::FUNC_W-1:0] func,
			logic [gbts_pkg::CHAR_W-1:0] char_in, logic [gbts_pkg::POS_W-1:0] position,
			bit known_result, edit_result_t typed);
		int gap;
		edit_result_t predicted;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {{(gbts_pkg::IN_W - gbts_pkg::CHAR_W - gbts_pkg::POS_W){1'b0}},
			position, char_in};
		s_tuser  = func;
		do @(posedge clk); while (!s_tready);
		predicted = apply_edit(func, char_in, position);
		pending_results.push_back(known_result ? typed : predicted);
		op_count[func]++;
		status_count[predicted.status]++;
		if (shadow_length() > peak_length) begin
			peak_length = shadow_length();
		end
	endtask

	function automatic void add_row(logic [gbts_pkg::FUNC_W-1:0] func,
			logic [gbts_pkg::CHAR_W-1:0] char_in, logic [gbts_pkg::POS_W-1:0] position,
			bit known_result, logic [gbts_pkg::STATUS_W-1:0] status,
			logic [gbts_pkg::CHAR_W-1:0] char_out, int cursor, int length);
		edit_row_t row;
		row.func         = func;
		row.char_in      = char_in;
		row.position     = position;
		row.known_result = known_result;
		row.result       = '{status, char_out, gbts_pkg::POS_W'(cursor),
			gbts_pkg::POS_W'(length)};
		directed_rows.push_back(row);
	endfunction

	// Random target for a move: mostly inside the text, with the ends and
	// targets past the end mixed in.
	function automatic logic [gbts_pkg::POS_W-1:0] pick_move_target();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return gbts_pkg::POS_W'(shadow_length());
		end else if (r == 2) begin
			return gbts_pkg::POS_W'($urandom_range(shadow_length(), 2047));
		end
		return gbts_pkg::POS_W'($urandom_range(0, shadow_length()));
	endfunction

	// Random index for a read: mostly a valid index, sometimes past the end.
	function automatic logic [gbts_pkg::POS_W-1:0] pick_read_index();
		int r;
		r = $urandom_range(0, 9);
		if (shadow_length() == 0 || r < 2) begin
			return gbts_pkg::POS_W'($urandom_range(shadow_length(), 2047));
		end else if (r == 2) begin
			return gbts_pkg::POS_W'(shadow_length() - 1);
		end
		return gbts_pkg::POS_W'($urandom_range(0, shadow_length() - 1));
	endfunction

	// Weighted choice of an operation; the read weight is what remains of 100.
	task automatic send_random_edit(int w_insert, int w_delete, int w_move);
		int r;
		edit_result_t unused;
		r = $urandom_range(0, 99);
		unused = '0;
		if (r < w_insert) begin
			send_edit(gbts_pkg::OP_INSERT, gbts_pkg::CHAR_W'($urandom_range(0, 255)), '0,
				1'b0, unused);
		end else if (r < w_insert + w_delete) begin
			send_edit(gbts_pkg::OP_DELETE, gbts_pkg::CHAR_W'($urandom_range(0, 255)),
				gbts_pkg::POS_W'($urandom_range(0, 2047)), 1'b0, unused);
		end else if (r < w_insert + w_delete + w_move) begin
			send_edit(gbts_pkg::OP_MOVE, gbts_pkg::CHAR_W'($urandom_range(0, 255)),
				pick_move_target(), 1'b0, unused);
		end else begin
			send_edit(gbts_pkg::OP_READ, gbts_pkg::CHAR_W'($urandom_range(0, 255)),
				pick_read_index(), 1'b0, unused);
		end
	endtask

	// Result side: ready with random stalls, mostly short and a few long.
	initial begin
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (no_idle) begin
				m_tready = 1'b1;
				hold     = 0;
			end else if (hold > 0) begin
				hold--;
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						m_tready = 1'b0;
						hold     = $urandom_range(20, 80);
					end
					1, 2, 3, 4, 5, 6: begin
						m_tready = 1'b0;
						hold     = $urandom_range(0, 3);
					end
					default: begin
						m_tready = 1'b1;
						hold     = $urandom_range(0, 6);
					end
				endcase
			end
		end
	end

	// Result checker: every accepted result is matched with the oldest
	// outstanding prediction, one field at a time.
	always @(posedge clk) begin
		edit_result_t got;
		edit_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[1:0], m_tdata[9:2], m_tdata[20:10], m_tdata[31:21]};
			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, raw data", 0, int'(m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					report_mismatch("status", want.status, got.status);
				end
				if (got.char_out !== want.char_out) begin
					report_mismatch("char_out", want.char_out, got.char_out);
				end
				if (got.cursor !== want.cursor) begin
					report_mismatch("cursor", want.cursor, got.cursor);
				end
				if (got.text_length !== want.text_length) begin
					report_mismatch("text_length", want.text_length, got.text_length);
				end
			end
		end
	end

	initial begin
		int drain_cycles;
		int n_items;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = gbts_pkg::OP_INSERT;
		no_idle         = 1'b0;
		mismatch_count  = 0;
		results_checked = 0;
		peak_length     = 0;
		n_items         = 0;
		op_count        = '{default: 0};
		status_count    = '{default: 0};
		gap_lo          = 0;
		gap_hi          = gbts_pkg::CAPACITY;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed table. The empty buffer gives the error codes and the
		// clamped move at a glance; after three inserts the first reads and
		// both ends of the index range are easy to type in too.
		add_row(gbts_pkg::OP_DELETE, 8'h00, 11'd0,    1, gbts_pkg::ST_EMPTY, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_READ,   8'hff, 11'd0,    1, gbts_pkg::ST_RANGE, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_MOVE,   8'h00, 11'd2047, 1, gbts_pkg::ST_OK,    8'h00, 0, 0);
		add_row(gbts_pkg::OP_INSERT, 8'h00, 11'd2047, 1, gbts_pkg::ST_OK,    8'h00, 1, 1);
		add_row(gbts_pkg::OP_INSERT, 8'hff, 11'd0,    1, gbts_pkg::ST_OK,    8'h00, 2, 2);
		add_row(gbts_pkg::OP_INSERT, 8'ha5, 11'd5,    1, gbts_pkg::ST_OK,    8'h00, 3, 3);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd0,    1, gbts_pkg::ST_OK,    8'h00, 3, 3);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd1,    1, gbts_pkg::ST_OK,    8'hff, 3, 3);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd3,    1, gbts_pkg::ST_RANGE, 8'h00, 3, 3);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd2047, 1, gbts_pkg::ST_RANGE, 8'h00, 3, 3);
		// From here the predictor supplies the answers: reads across the gap,
		// moves in both directions, backspace and the empty prefix again.
		add_row(gbts_pkg::OP_MOVE,   8'h00, 11'd1,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd2,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd1,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_INSERT, 8'h5a, 11'd0,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd2,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_MOVE,   8'h00, 11'd1024, 0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_DELETE, 8'hff, 11'd2047, 0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd3,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_MOVE,   8'h00, 11'd0,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_DELETE, 8'h00, 11'd0,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd0,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_INSERT, 8'h80, 11'd0,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_MOVE,   8'h00, 11'd2,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		add_row(gbts_pkg::OP_READ,   8'h00, 11'd1,    0, gbts_pkg::ST_OK, 8'h00, 0, 0);
		foreach (directed_rows[i]) begin
			send_edit(directed_rows[i].func, directed_rows[i].char_in,
				directed_rows[i].position, directed_rows[i].known_result,
				directed_rows[i].result);
		end

		// Growth session: mostly typing, with reads, moves and a little
		// backspace mixed in, until the buffer has been full several times
		// over. Every hundred items the idling is switched off now and then.
		while (status_count[gbts_pkg::ST_FULL] < 6) begin
			if (n_items % 100 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
			end
			send_random_edit(85, 2, 6);
			n_items++;
		end

		// Editing session on the full text: heavy on backspace and moves, so
		// the text shrinks again and the cursor reaches the start.
		repeat (160) begin
			if (n_items % 100 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
			end
			send_random_edit(20, 35, 20);
			n_items++;
		end
		no_idle = 1'b0;

		@(negedge clk);
		s_tvalid = 1'b0;
		drain_cycles = 0;
		while (pending_results.size() != 0 && drain_cycles < 200_000) begin
			@(posedge clk);
			drain_cycles++;
		end
		// Any result beyond the last one would show up within this wait.
		repeat (50) @(posedge clk);
		if (pending_results.size() != 0) begin
			report_mismatch("results still missing at the end, count", 0,
				pending_results.size());
		end

		$display("ran %0d items: %0d inserts, %0d deletes, %0d moves, %0d reads",
			op_count[gbts_pkg::OP_INSERT] + op_count[gbts_pkg::OP_DELETE]
				+ op_count[gbts_pkg::OP_MOVE] + op_count[gbts_pkg::OP_READ],
			op_count[gbts_pkg::OP_INSERT], op_count[gbts_pkg::OP_DELETE],
			op_count[gbts_pkg::OP_MOVE], op_count[gbts_pkg::OP_READ]);
		$display("outcomes: %0d ok, %0d full, %0d empty prefix, %0d bad index; peak length %0d",
			status_count[gbts_pkg::ST_OK], status_count[gbts_pkg::ST_FULL],
			status_count[gbts_pkg::ST_EMPTY], status_count[gbts_pkg::ST_RANGE], peak_length);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
